>>> hdl/lcpa_pkg.sv
// lcpa_pkg: shared types and constants for the load cell pressure averager
// used by lcpa_ring, lcpa_div and the top level load_cell_pressure_averager
`default_nettype none

package lcpa_pkg;

  // default ring depth in items
  localparam int SAMPLES_DEF = 16;

  // converter word and result field widths
  localparam int RAW_W  = 24;
  localparam int AVG_W  = 32;
  localparam int PRES_W = 24;
  localparam int REG_W  = 32;

  // shared divider: signed numerator and denominator, magnitudes one bit narrower
  localparam int NUM_W     = 41;
  localparam int NUM_MAG_W = NUM_W - 1;
  localparam int DEN_W     = 33;
  localparam int DEN_MAG_W = DEN_W - 1;
  localparam int CNT_W     = $clog2(NUM_MAG_W + 1);

  // 7.50062 in Q.16, rounded to nearest
  localparam int MMHG_W = 20;
  localparam logic signed [MMHG_W-1:0] MMHG_PER_KPA_Q16 = 20'sd491561;

  localparam int PROD_W = PRES_W + MMHG_W;

  // register map, word index on the configuration port
  localparam int CFG_ADDR_W = 3;
  typedef enum logic {
    REG_ZERO_OFFSET    = 1'b0,
    REG_COUNTS_PER_KPA = 1'b1
  } cfg_reg_t;

  // input command codes
  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  // ring control from the sequencer
  typedef struct packed {
    logic clr;
    logic rd;
    logic upd;
  } ring_ctl_t;

endpackage

`default_nettype wire

>>> hdl/lcpa_ring.sv
// lcpa_ring: sample ring memory with running sum and saturating fill count
// depends on lcpa_pkg
`default_nettype none

module lcpa_ring #(
  parameter int SAMPLES = lcpa_pkg::SAMPLES_DEF,
  parameter int PTR_W   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1,
  parameter int FILL_W  = $clog2(SAMPLES + 1),
  parameter int SUM_W   = lcpa_pkg::RAW_W + FILL_W
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire lcpa_pkg::ring_ctl_t          ctl,
  input  wire logic signed [lcpa_pkg::RAW_W-1:0] sample,
  output logic signed [SUM_W-1:0]           sum,
  output logic [FILL_W-1:0]                 fill
);
  import lcpa_pkg::*;

  logic [RAW_W-1:0]        mem_r [SAMPLES];
  logic [RAW_W-1:0]        rd_data_r;
  logic [PTR_W-1:0]        wp_r, wp_nxt;
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                    full;
  logic signed [SUM_W-1:0] old_ext, new_ext;

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_data_r <= mem_r[wp_r];
    end
    if (ctl.upd) begin
      mem_r[wp_r] <= sample;
    end
  end

  // entries ahead of the write pointer hold data only once the ring has wrapped
  assign full    = (fill_r == FILL_W'(SAMPLES));
  assign old_ext = full ? {{(SUM_W-RAW_W){rd_data_r[RAW_W-1]}}, rd_data_r} : '0;
  assign new_ext = {{(SUM_W-RAW_W){sample[RAW_W-1]}}, sample};

  always_comb begin
    sum_nxt  = sum_r - old_ext + new_ext;
    wp_nxt   = (wp_r == PTR_W'(SAMPLES - 1)) ? '0 : wp_r + 1'b1;
    fill_nxt = full ? fill_r : fill_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      wp_r   <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else if (ctl.upd) begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

  assign sum  = sum_r;
  assign fill = fill_r;

endmodule

`default_nettype wire

>>> hdl/lcpa_div.sv
// lcpa_div: shared signed restoring divider, one quotient bit per cycle,
// quotient truncated toward zero; depends on lcpa_pkg
`default_nettype none

module lcpa_div (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     start,
  input  wire logic signed [lcpa_pkg::NUM_W-1:0]  num,
  input  wire logic signed [lcpa_pkg::DEN_W-1:0]  den,
  input  wire logic [lcpa_pkg::CNT_W-1:0]         nbits,
  output logic                                    done,
  output logic signed [lcpa_pkg::NUM_W-1:0]       quo
);
  import lcpa_pkg::*;

  logic                      busy_r;
  logic                      done_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      neg_r;
  logic [DEN_MAG_W-1:0]      rem_r, rem_nxt;
  logic [NUM_MAG_W-1:0]      acc_r, acc_nxt;
  logic [DEN_MAG_W-1:0]      d_r;
  logic signed [NUM_W-1:0]   quo_r;
  logic [NUM_W-1:0]          num_abs;
  logic [DEN_W-1:0]          den_abs;
  logic [DEN_MAG_W+1:0]      trial;
  logic                      ge;

  assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign den_abs = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

  always_comb begin
    trial   = {1'b0, rem_r, acc_r[NUM_MAG_W-1]} - {2'b00, d_r};
    ge      = !trial[DEN_MAG_W+1];
    rem_nxt = ge ? trial[DEN_MAG_W-1:0] : {rem_r[DEN_MAG_W-2:0], acc_r[NUM_MAG_W-1]};
    acc_nxt = {acc_r[NUM_MAG_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // align the significant numerator bits to the top of the shifter
      acc_r <= num_abs[NUM_MAG_W-1:0] << (CNT_W'(NUM_MAG_W) - nbits);
      rem_r <= '0;
      d_r   <= den_abs[DEN_MAG_W-1:0];
      neg_r <= num[NUM_W-1] ^ den[DEN_W-1];
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
      if (cnt_r == CNT_W'(1)) begin
        quo_r <= neg_r ? -$signed({1'b0, acc_nxt}) : $signed({1'b0, acc_nxt});
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

>>> hdl/load_cell_pressure_averager.sv
// load_cell_pressure_averager: top level with sequencer, registers and output stage
// depends on lcpa_pkg, lcpa_ring and lcpa_div
//
// Usage: each input item carries a 24-bit converter word on in_tdata and a command
// on in_tuser (0 = sample, 1 = clear the averaging ring). Each input item yields
// exactly one result item on the out_ channel: the raw signed sample, the moving
// average in Q24.8, pressure in kPa and mmHg (Q16.8, saturated) and the calibrated
// flag on out_tuser. zero_offset and counts_per_kpa are written over the cfg_ APB
// port at byte addresses 0 and 4; pressure is computed only when counts_per_kpa
// is nonzero, otherwise both pressure fields read 0.
// Timing: in_tready is high only while the sequencer is idle. A sample item uses the
// shared divider, which retires one quotient bit per cycle, once for the average and,
// when calibrated, once for kPa. The result waits in the output register while the
// next item is taken; if the receiver stalls, a further result holds the sequencer
// until the register frees. Reset empties the ring and clears both calibration registers.
`default_nettype none

module load_cell_pressure_averager #(
  parameter int SAMPLES = lcpa_pkg::SAMPLES_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // in_tdata: raw_code[23:0]
  input  wire logic [lcpa_pkg::RAW_W-1:0]       in_tdata,
  // in_tuser: cmd[0]
  input  wire logic                             in_tuser,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  // out_tdata: raw_signed[23:0], filtered_counts[55:24], pressure_kpa[79:56],
  // pressure_mmhg[103:80]
  output logic [103:0]                          out_tdata,
  // out_tuser: calibrated[0]
  output logic                                  out_tuser,
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  input  wire                                   cfg_psel,
  input  wire                                   cfg_penable,
  input  wire                                   cfg_pwrite,
  input  wire logic [lcpa_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [lcpa_pkg::REG_W-1:0]       cfg_pwdata,
  output logic [lcpa_pkg::REG_W-1:0]            cfg_prdata,
  output logic                                  cfg_pready
);
  import lcpa_pkg::*;

  localparam int PTR_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int FILL_W = $clog2(SAMPLES + 1);
  localparam int SUM_W  = RAW_W + FILL_W;
  localparam int SH_W   = PROD_W - 16 + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_UPD,
    S_AVG_GO,
    S_AVG_WAIT,
    S_KPA_GO,
    S_KPA_WAIT,
    S_KSAT,
    S_PROD,
    S_MSAT,
    S_DONE
  } state_t;

  state_t                    state_r;
  logic signed [REG_W-1:0]   offset_r, gain_r;
  logic signed [RAW_W-1:0]   raw_r;
  logic signed [AVG_W-1:0]   avg_r;
  logic signed [NUM_W-1:0]   kpa_r;
  logic signed [PRES_W-1:0]  kpa_sat_r, mmhg_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      cal_r;
  logic [103:0]              out_data_r;
  logic                      out_user_r, out_valid_r;

  logic                      cfg_wr;
  logic                      in_fire;
  logic                      out_load;
  ring_ctl_t                 ring_ctl;
  logic signed [SUM_W-1:0]   ring_sum;
  logic [FILL_W-1:0]         ring_fill;
  logic                      div_start, div_done;
  logic signed [NUM_W-1:0]   div_num, div_quo;
  logic signed [DEN_W-1:0]   div_den;
  logic [CNT_W-1:0]          div_nbits;
  logic signed [AVG_W:0]     diff;
  logic signed [PRES_W-1:0]  kpa_sat;
  logic signed [PROD_W:0]    prod_adj;
  logic signed [SH_W-1:0]    mmhg_sh;
  logic signed [PRES_W-1:0]  mmhg_sat;
  logic signed [PROD_W-1:0]  prod_nxt;

  // configuration port
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_reg_t'(cfg_paddr[2]) == REG_COUNTS_PER_KPA) ? gain_r : offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      gain_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_paddr[2]))
        REG_ZERO_OFFSET:    offset_r <= cfg_pwdata;
        REG_COUNTS_PER_KPA: gain_r   <= cfg_pwdata;
        default:            offset_r <= offset_r;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // hand the item to the output register once it is free
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    ring_ctl.clr = in_fire && (cmd_t'(in_tuser) == CMD_CLEAR);
    ring_ctl.rd  = (state_r == S_READ);
    ring_ctl.upd = (state_r == S_UPD);
  end

  lcpa_ring #(
    .SAMPLES (SAMPLES),
    .PTR_W   (PTR_W),
    .FILL_W  (FILL_W),
    .SUM_W   (SUM_W)
  ) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ring_ctl),
    .sample (raw_r),
    .sum    (ring_sum),
    .fill   (ring_fill)
  );

  // divider operands: average first, then kPa
  always_comb begin
    diff = {avg_r[AVG_W-1], avg_r} - {offset_r[REG_W-1], offset_r};
    if (state_r == S_KPA_GO) begin
      div_num   = {diff, 8'h00};
      div_den   = {gain_r[REG_W-1], gain_r};
      div_nbits = CNT_W'(NUM_MAG_W);
    end else begin
      div_num   = {{(NUM_W-8-SUM_W){ring_sum[SUM_W-1]}}, ring_sum, 8'h00};
      div_den   = DEN_W'(ring_fill);
      div_nbits = CNT_W'(SUM_W + 8);
    end
    div_start = (state_r == S_AVG_GO) || (state_r == S_KPA_GO);
  end

  lcpa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .nbits (div_nbits),
    .done  (div_done),
    .quo   (div_quo)
  );

  // saturation and mmHg scaling; a saturated kPa always saturates mmHg the same way
  always_comb begin
    if (kpa_r > NUM_W'(signed'(24'sh7fffff))) begin
      kpa_sat = 24'sh7fffff;
    end else if (kpa_r < -NUM_W'(signed'(25'sh0800000))) begin
      kpa_sat = -24'sh800000;
    end else begin
      kpa_sat = kpa_r[PRES_W-1:0];
    end
    prod_nxt = kpa_sat_r * MMHG_PER_KPA_Q16;
    prod_adj = {prod_r[PROD_W-1], prod_r} + (prod_r[PROD_W-1] ? (PROD_W+1)'(16'hffff) : '0);
    mmhg_sh  = prod_adj[PROD_W:16];
    if (mmhg_sh > SH_W'(signed'(24'sh7fffff))) begin
      mmhg_sat = 24'sh7fffff;
    end else if (mmhg_sh < -SH_W'(signed'(25'sh0800000))) begin
      mmhg_sat = -24'sh800000;
    end else begin
      mmhg_sat = mmhg_sh[PRES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cal_r     <= (gain_r != '0);
            kpa_sat_r <= '0;
            mmhg_r    <= '0;
            avg_r     <= '0;
            if (cmd_t'(in_tuser) == CMD_CLEAR) begin
              raw_r   <= '0;
              state_r <= S_DONE;
            end else begin
              raw_r   <= in_tdata;
              state_r <= S_READ;
            end
          end
        end
        S_READ:   state_r <= S_UPD;
        S_UPD:    state_r <= S_AVG_GO;
        S_AVG_GO: state_r <= S_AVG_WAIT;
        S_AVG_WAIT: begin
          if (div_done) begin
            avg_r   <= div_quo[AVG_W-1:0];
            state_r <= cal_r ? S_KPA_GO : S_DONE;
          end
        end
        S_KPA_GO: state_r <= S_KPA_WAIT;
        S_KPA_WAIT: begin
          if (div_done) begin
            kpa_r   <= div_quo;
            state_r <= S_KSAT;
          end
        end
        S_KSAT: begin
          kpa_sat_r <= kpa_sat;
          state_r   <= S_PROD;
        end
        S_PROD: begin
          prod_r  <= prod_nxt;
          state_r <= S_MSAT;
        end
        S_MSAT: begin
          mmhg_r  <= mmhg_sat;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_data_r <= {mmhg_r, kpa_sat_r, avg_r, raw_r};
            out_user_r <= cal_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input taken while an item is in progress");

  a_uncal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[103:56] == '0))
    else $error("pressure fields nonzero on an uncalibrated item");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ring_fill <= FILL_W'(SAMPLES))
    else $error("fill count beyond ring depth");

  a_div_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_AVG_WAIT || state_r == S_KPA_WAIT))
    else $error("divider finished outside a wait state");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// testbench for load_cell_pressure_averager: random bursty stream traffic,
// configuration phases over the APB port and an item-level predictor.
// depends on lcpa_pkg and the RTL of load_cell_pressure_averager
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lcpa_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 120;
  localparam longint Q16_ONE = 65536;

  typedef struct packed {
    cmd_t        cmd;
    logic [23:0] code;
  } sensor_item_t;

  typedef struct packed {
    logic [23:0] raw;
    logic [31:0] avg;
    logic [23:0] kpa;
    logic [23:0] mmhg;
    logic        cal;
  } reading_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic [23:0]  in_tdata;
  logic         in_tuser;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] out_tdata;
  logic         out_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  // predictor state
  logic signed [23:0] ring_mem [SAMPLES_DEF];
  int           wr_pos;
  int           fill_cnt;
  longint       ring_sum;
  longint       offset_q8;
  longint       gain_q8;

  sensor_item_t pending_q[$];
  reading_t     reading_q[$];
  int           err_count;
  int           cycle_count;

  // driver pacing
  int           burst_left;
  int           gap_left;

  // receiver stall pattern
  int           rdy_mode;
  int           rdy_left;
  logic [15:0]  rdy_mask;
  reading_t     got_r;
  reading_t     exp_r;

  load_cell_pressure_averager #(
    .SAMPLES(SAMPLES_DEF)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #1 clk = ~clk;

  function automatic logic [23:0] sat_q16_8(input longint v);
    if (v > 64'sd8388607) return 24'h7FFFFF;
    if (v < -64'sd8388608) return 24'h800000;
    return v[23:0];
  endfunction

  // updates the ring and returns the reading the block should give
  function automatic reading_t predict_reading(input cmd_t cmd, input logic [23:0] code);
    reading_t r;
    longint smp;
    longint avg;
    longint kpa;
    longint mmhg;
    r = '0;
    r.cal = (gain_q8 != 0);
    if (cmd == CMD_CLEAR) begin
      for (int i = 0; i < SAMPLES_DEF; i++) ring_mem[i] = '0;
      wr_pos = 0;
      fill_cnt = 0;
      ring_sum = 0;
    end else begin
      smp = $signed(code);
      ring_sum = ring_sum - ring_mem[wr_pos] + smp;
      ring_mem[wr_pos] = code;
      wr_pos = (wr_pos + 1) % SAMPLES_DEF;
      if (fill_cnt < SAMPLES_DEF) fill_cnt++;
      avg = (ring_sum * 256) / fill_cnt;
      r.raw = code;
      r.avg = avg[31:0];
      if (r.cal) begin
        kpa = ((avg - offset_q8) * 256) / gain_q8;
        // mmHg from the unsaturated kPa value
        mmhg = (kpa * MMHG_PER_KPA_Q16) / Q16_ONE;
        r.kpa = sat_q16_8(kpa);
        r.mmhg = sat_q16_8(mmhg);
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 0;
      4, 5, 6:    return $urandom_range(1, 4);
      7, 8:       return $urandom_range(5, 60);
      default:    return $urandom_range(61, 130);
    endcase
  endfunction

  // sender: bursts of items separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        reading_q.push_back(predict_reading(cmd_t'(in_tuser), in_tdata));
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_tuser <= pending_q[0].cmd;
          in_tdata <= pending_q[0].code;
          pending_q.delete(0);
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= pick_gap();
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
      err_count++;
    end
  endtask

  // receiver: checks results and stalls on its own pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rdy_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_r.raw  = out_tdata[23:0];
        got_r.avg  = out_tdata[55:24];
        got_r.kpa  = out_tdata[79:56];
        got_r.mmhg = out_tdata[103:80];
        got_r.cal  = out_tuser;
        if (reading_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, got_r);
          err_count++;
        end else begin
          exp_r = reading_q.pop_front();
          check_field("raw_signed", 32'(exp_r.raw), 32'(got_r.raw));
          check_field("filtered_counts", exp_r.avg, got_r.avg);
          check_field("pressure_kpa", 32'(exp_r.kpa), 32'(got_r.kpa));
          check_field("pressure_mmhg", 32'(exp_r.mmhg), 32'(got_r.mmhg));
          check_field("calibrated", 32'(exp_r.cal), 32'(got_r.cal));
        end
      end
      if (rdy_left == 0) begin
        rdy_mode = $urandom_range(0, 3);
        rdy_left = $urandom_range(30, 400);
        rdy_mask = 16'($urandom);
      end
      rdy_left--;
      case (rdy_mode)
        0: out_tready <= 1'b1;
        1: begin
          out_tready <= rdy_mask[0];
          rdy_mask = {rdy_mask[0], rdy_mask[15:1]};
        end
        // long stalls with a single ready cycle now and then
        2: out_tready <= (rdy_left[5:0] == 6'd0);
        default: begin
          out_tready <= rdy_mask[0] | rdy_mask[1];
          rdy_mask = {rdy_mask[0], rdy_mask[15:1]};
        end
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic cfg_access(input logic wr, input cfg_reg_t idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_calibration(input logic [31:0] off, input logic [31:0] gain);
    logic [31:0] rd;
    cfg_access(1'b1, REG_ZERO_OFFSET, off, rd);
    offset_q8 = longint'($signed(off));
    cfg_access(1'b1, REG_COUNTS_PER_KPA, gain, rd);
    gain_q8 = longint'($signed(gain));
    cfg_access(1'b0, REG_ZERO_OFFSET, '0, rd);
    check_field("zero_offset readback", off, rd);
    cfg_access(1'b0, REG_COUNTS_PER_KPA, '0, rd);
    check_field("counts_per_kpa readback", gain, rd);
  endtask

  task automatic add_item(input cmd_t c, input logic [23:0] code);
    sensor_item_t it;
    it.cmd = c;
    it.code = code;
    pending_q.push_back(it);
  endtask

  task automatic wait_for_drain();
    while (pending_q.size() != 0 || in_tvalid || reading_q.size() != 0) @(negedge clk);
  endtask

  // mostly noisy readings around a base level, some full range, extremes and clears
  task automatic queue_samples(input int n, input logic [23:0] base);
    logic [23:0] code;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 99))
        0, 1, 2, 3: add_item(CMD_CLEAR, 24'($urandom));
        4, 5, 6, 7, 8, 9: begin
          case ($urandom_range(0, 3))
            0: code = 24'h7FFFFF;
            1: code = 24'h800000;
            2: code = 24'h000000;
            default: code = 24'hFFFFFF;
          endcase
          add_item(CMD_SAMPLE, code);
        end
        10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20, 21, 22, 23, 24, 25, 26, 27, 28, 29, 30, 31,
        32, 33, 34, 35, 36, 37, 38, 39: add_item(CMD_SAMPLE, 24'($urandom));
        default: add_item(CMD_SAMPLE, base + 24'($urandom_range(0, 2047)) - 24'd1024);
      endcase
    end
  endtask

  logic [23:0] base;
  logic [31:0] off_v;
  logic [31:0] gain_v;

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_SAMPLE;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    err_count = 0;
    cycle_count = 0;
    for (int i = 0; i < SAMPLES_DEF; i++) ring_mem[i] = '0;
    wr_pos = 0;
    fill_cnt = 0;
    ring_sum = 0;
    offset_q8 = 0;
    gain_q8 = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // uncalibrated after reset, field extremes and a clear
    add_item(CMD_SAMPLE, 24'h000000);
    add_item(CMD_SAMPLE, 24'h7FFFFF);
    add_item(CMD_SAMPLE, 24'h800000);
    add_item(CMD_SAMPLE, 24'hFFFFFF);
    add_item(CMD_SAMPLE, 24'h000001);
    add_item(CMD_CLEAR, 24'hFFFFFF);
    wait_for_drain();

    // unity gain, full scale past ring wrap saturates both pressures high
    set_calibration(32'h0000_0000, 32'h0000_0100);
    for (int k = 0; k < SAMPLES_DEF + 1; k++) add_item(CMD_SAMPLE, 24'h7FFFFF);
    wait_for_drain();

    // most negative offset with gain of -1 saturates low
    set_calibration(32'h8000_0000, 32'hFFFF_FFFF);
    add_item(CMD_CLEAR, 24'h000000);
    add_item(CMD_SAMPLE, 24'h7FFFFF);
    wait_for_drain();

    for (int ph = 0; ph < 8; ph++) begin
      base = 24'($urandom);
      case (ph)
        0: begin
          off_v = 32'h7FFF_FFFF;
          gain_v = 32'h8000_0000;
        end
        1: begin
          off_v = $urandom;
          gain_v = 32'h7FFF_FFFF;
        end
        default: begin
          case ($urandom_range(0, 4))
            0: off_v = 32'h0000_0000;
            1: off_v = 32'h8000_0000;
            2: off_v = 32'h7FFF_FFFF;
            3: off_v = $urandom;
            default: off_v = {base, 8'h00} + 32'($urandom_range(0, 65535)) - 32'd32768;
          endcase
          case ($urandom_range(0, 5))
            0: gain_v = 32'h0000_0000;
            1: gain_v = ($urandom_range(0, 1) != 0) ? 32'h0000_0001 : 32'hFFFF_FFFF;
            2: gain_v = $urandom;
            default: begin
              gain_v = $urandom_range(1 << 12, 1 << 22);
              if ($urandom_range(0, 1) != 0) gain_v = -gain_v;
            end
          endcase
        end
      endcase
      set_calibration(off_v, gain_v);
      queue_samples(33, base);
      // let every result come home before the rest of this run
      if (ph == 3) wait_for_drain();
      queue_samples(33, base);
      wait_for_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
